/* sv/blist_pkg.sv */
package blist_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // One write port and one read port into the entry memory
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } store_req_t;

endpackage

/* sv/blist_store.sv */
module blist_store (
  input  logic                          clk,
  input  blist_pkg::store_req_t         req,
  output logic [blist_pkg::VALUE_W-1:0] rdata
);

  logic [blist_pkg::VALUE_W-1:0] mem [blist_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* sv/blist_seq.sv */
module blist_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [31:0]            value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          success,
  output logic                          is_empty,
  output logic [blist_pkg::TOTAL_W-1:0] entry_total,
  output blist_pkg::store_req_t         req,
  input  logic [blist_pkg::VALUE_W-1:0] rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIN
  } state_t;

  state_t                        state;
  logic [1:0]                    cur_mode;
  logic [blist_pkg::VALUE_W-1:0] cur_value;
  logic [blist_pkg::CNT_W-1:0]   count;
  logic [blist_pkg::CNT_W-1:0]   idx;
  logic [blist_pkg::CNT_W-1:0]   idx_inc;
  logic                          ok;
  logic                          hit;

  assign in_ready = (state == ST_IDLE);
  assign idx_inc  = idx + 1'b1;
  // Shared comparator: every scan step goes through this one compare
  assign hit      = (rdata == cur_value);

  always_comb begin
    req = '0;
    unique case (state)
      ST_INS: begin
        req.we    = (count < blist_pkg::CAP_CNT);
        req.waddr = count[blist_pkg::IDX_W-1:0];
        req.wdata = cur_value;
      end
      ST_RD:    req.raddr = idx[blist_pkg::IDX_W-1:0];
      ST_SH_RD: req.raddr = idx_inc[blist_pkg::IDX_W-1:0];
      ST_SH_WR: begin
        req.we    = 1'b1;
        req.waddr = idx[blist_pkg::IDX_W-1:0];
        req.wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // ST_FIN drives out_valid itself
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_mode  <= mode;
            cur_value <= value;
            idx       <= '0;
            unique case (mode)
              blist_pkg::MODE_INSERT: state <= ST_INS;
              blist_pkg::MODE_SEARCH,
              blist_pkg::MODE_REMOVE: state <= ST_RD;
              default: begin
                ok    <= 1'b0;
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_INS: begin
          if (count < blist_pkg::CAP_CNT) begin
            count <= count + 1'b1;
            ok    <= 1'b1;
          end else begin
            ok <= 1'b0;
          end
          state <= ST_FIN;
        end
        ST_RD: begin
          if (idx < count) begin
            state <= ST_CMP;
          end else begin
            ok    <= 1'b0;
            state <= ST_FIN;
          end
        end
        ST_CMP: begin
          if (hit) begin
            if (cur_mode == blist_pkg::MODE_SEARCH) begin
              ok    <= 1'b1;
              state <= ST_FIN;
            end else begin
              state <= ST_SH_RD;
            end
          end else begin
            idx   <= idx_inc;
            state <= ST_RD;
          end
        end
        ST_SH_RD: begin
          // Pull the next entry down, or drop the tail once the gap reaches it
          if (idx_inc < count) begin
            state <= ST_SH_WR;
          end else begin
            count <= count - 1'b1;
            ok    <= 1'b1;
            state <= ST_FIN;
          end
        end
        ST_SH_WR: begin
          idx   <= idx_inc;
          state <= ST_SH_RD;
        end
        ST_FIN: begin
          // Hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            success     <= ok;
            is_empty    <= (count == '0);
            entry_total <= blist_pkg::TOTAL_W'(count);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= blist_pkg::CAP_CNT)
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS && count < blist_pkg::CAP_CNT) |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    req.we |-> (state == ST_INS || state == ST_SH_WR))
    else $error("memory write outside insert or shift");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SH_WR |-> idx_inc < count)
    else $error("shift beyond the tail");

endmodule

/* sv/bounded_value_list_top.sv */
// Ordered list of up to CAPACITY signed 32-bit values in a single-port-read entry
// memory. Each request (insert at tail, search, remove first match) gives one result
// with success, an empty flag and the entry count. Requests are taken one at a time:
// insert writes at the tail; search and remove walk the list entry by entry through
// one registered memory read and one shared comparator, and remove then moves each
// later entry down one place. A finished result waits in the output register while
// the next request is transferred in.
module bounded_value_list_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [31:0]            value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          success,
  output logic                          is_empty,
  output logic [blist_pkg::TOTAL_W-1:0] entry_total
);

  blist_pkg::store_req_t         req;
  logic [blist_pkg::VALUE_W-1:0] rdata;

  blist_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  blist_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .success     (success),
    .is_empty    (is_empty),
    .entry_total (entry_total),
    .req         (req),
    .rdata       (rdata)
  );

endmodule
